// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every rising clock edge outside reset.
`define ASSERT_AT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER_AT(label, clk, rst_n, cond) \
  `ASSERT_AT(label, clk, rst_n, !(cond))
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_NEVER_AT(label, clk, rst_n, cond)
`endif
`endif

// ----- rtl/core/dtsc_pkg.sv -----
`timescale 1ns / 1ps
package dtsc_pkg;

  // Field widths.
  localparam int unsigned TimeW  = 24;
  localparam int unsigned LimW   = 12;
  localparam int unsigned ClipW  = 5;
  localparam int unsigned MaxClips = 7;
  localparam int unsigned CntW   = 3;
  localparam int unsigned IdxW   = 3;

  // Echo times at or above 2^SmallTimeW always give 4456 cm or more.
  localparam int unsigned SmallTimeW = 18;
  // 17 * t for a small time fits here.
  localparam int unsigned ProdW = SmallTimeW + 5;
  // Divide by 1000 as a shift by 3 and a reciprocal multiply for / 125.
  localparam int unsigned DivInW  = ProdW - 3;
  localparam int unsigned RecipW  = 21;
  localparam int unsigned RecipShift = 27;
  localparam logic [RecipW-1:0] RecipMul = 21'd1073742;
  localparam int unsigned MulW = DivInW + RecipW;
  // Quotient width: distances up to 4456 fit in 13 bits.
  localparam int unsigned QuotW = 13;

  localparam logic [LimW-1:0]  LimitReset   = 12'd400;
  localparam logic [QuotW-1:0] SpeakLimit   = 13'd4000;

  // Clip codes.
  localparam logic [ClipW-1:0] ClipZero     = 5'd0;
  localparam logic [ClipW-1:0] ClipTeenBase = 5'd10;
  localparam logic [ClipW-1:0] ClipTensBase = 5'd18;
  localparam logic [ClipW-1:0] ClipHundred  = 5'd28;
  localparam logic [ClipW-1:0] ClipThousand = 5'd29;
  localparam logic [ClipW-1:0] ClipCm       = 5'd30;
  localparam logic [ClipW-1:0] ClipError    = 5'd31;

  // Distance result leaving the front end.
  typedef struct packed {
    logic            valid;
    logic            err;
    logic [LimW-1:0] dist_cm;
  } front_t;

  // Clip list of one measurement.
  typedef struct packed {
    logic                           valid;
    logic [MaxClips-1:0][ClipW-1:0] clips;
    logic [CntW-1:0]                cnt;
  } clip_list_t;

endpackage

// ----- rtl/core/distance_to_spoken_clips.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_axis    in         tdata[23:0] echo_time_us
// m_axis    out        tdata[4:0] clip, tlast last_clip
// cfg       in         cfg_data_i[11:0] max_distance
//
// A measurement passes seven pipeline stages and then the serializer register
// before its first clip shows on the output.
// It then holds the output for one cycle per clip while m_axis_tready is high,
// 1 to 7 clips, paced by the clip serializer; the pipeline advances while the serializer loads.
// Reset clears all valid bits and sets max_distance to 400.
// An output stall freezes the whole pipeline; nothing is dropped or repeated.
module distance_to_spoken_clips
  import dtsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [TimeW-1:0] s_axis_tdata,   // [23:0] echo_time_us
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [4:0] clip, [7:5] zero
  output logic             m_axis_tlast,   // last_clip
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LimW-1:0]  cfg_data_i      // [11:0] max_distance
);

  logic [LimW-1:0] max_q;
  logic            en;
  front_t          front;
  clip_list_t      list;

  // Limit register; writes are always taken.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= LimitReset;
    end else if (cfg_valid_i) begin
      max_q <= cfg_data_i;
    end
  end

  assign s_axis_tready = en;

  dtsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .time_i     (s_axis_tdata),
    .max_dist_i (max_q),
    .out_o      (front)
  );

  dtsc_digit u_digit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .in_i   (front),
    .out_o  (list)
  );

  dtsc_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .list_i        (list),
    .load_o        (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- rtl/core/dtsc_front.sv -----
`timescale 1ns / 1ps
module dtsc_front
  import dtsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [TimeW-1:0] time_i,
  input  logic [LimW-1:0]  max_dist_i,
  output front_t           out_o
);

  logic              v1_q, big1_q;
  logic [ProdW-1:0]  p1_q, p1_d;
  logic              v2_q, big2_q;
  logic [QuotW-1:0]  q2_q, q2_d;
  logic [MulW-1:0]   prod;
  logic              v3_q, err3_q, err3_d;
  logic [LimW-1:0]   dist3_q;

  // Stage 1: scale by 17 as t * 16 + t; flag times that are surely too far.
  assign p1_d = ProdW'({time_i[SmallTimeW-1:0], 4'b0000})
              + ProdW'(time_i[SmallTimeW-1:0]);

  // Stage 2: floor(p / 1000) = floor((p >> 3) / 125) by reciprocal multiply.
  assign prod = MulW'(p1_q[ProdW-1:3]) * MulW'(RecipMul);
  assign q2_d = prod[RecipShift +: QuotW];

  // Stage 3: compare against the programmed limit and the speakable limit.
  assign err3_d = big2_q || (q2_q >= QuotW'(max_dist_i)) || (q2_q >= SpeakLimit);

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      big1_q  <= |time_i[TimeW-1:SmallTimeW];
      p1_q    <= p1_d;
      big2_q  <= big1_q;
      q2_q    <= q2_d;
      err3_q  <= err3_d;
      dist3_q <= q2_q[LimW-1:0];
    end
  end

  assign out_o.valid   = v3_q;
  assign out_o.err     = err3_q;
  assign out_o.dist_cm = dist3_q;

endmodule

// ----- rtl/core/dtsc_digit.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtsc_digit
  import dtsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  front_t     in_i,
  output clip_list_t out_o
);

  // Stage A registers: thousands digit and remainder below 1000.
  logic       va_q, erra_q, zeroa_q;
  logic [1:0] tha_q, tha_d;
  logic [9:0] rema_q, rema_d;
  // Stage B registers: hundreds digit and remainder below 100.
  logic       vb_q, errb_q, zerob_q;
  logic [1:0] thb_q;
  logic [3:0] hub_q, hub_d;
  logic [6:0] remb_q, remb_d;
  // Stage C registers: tens and ones digits.
  logic       vc_q, errc_q, zeroc_q;
  logic [1:0] thc_q;
  logic [3:0] huc_q, tnc_q, tnc_d, onc_q, onc_d;
  // Stage D registers: finished clip list.
  logic                           vd_q;
  logic [MaxClips-1:0][ClipW-1:0] clips_q, clips_d;
  logic [CntW-1:0]                cnt_q, cnt_d;

  // Stage A: thousands by compare chain, then subtract.
  always_comb begin
    if (in_i.dist_cm >= 12'd3000) begin
      tha_d = 2'd3;
    end else if (in_i.dist_cm >= 12'd2000) begin
      tha_d = 2'd2;
    end else if (in_i.dist_cm >= 12'd1000) begin
      tha_d = 2'd1;
    end else begin
      tha_d = 2'd0;
    end
    rema_d = 10'(in_i.dist_cm - 12'(tha_d) * 12'd1000);
  end

  // Stage B: hundreds from independent compares.
  always_comb begin
    hub_d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rema_q >= 10'(k * 100)) begin
        hub_d = 4'(k);
      end
    end
    remb_d = 7'(rema_q - 10'(hub_d) * 10'd100);
  end

  // Stage C: tens from independent compares.
  always_comb begin
    tnc_d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (remb_q >= 7'(k * 10)) begin
        tnc_d = 4'(k);
      end
    end
    onc_d = 4'(remb_q - 7'(tnc_d) * 7'd10);
  end

  // Stage D: put the words in speaking order.
  always_comb begin
    logic [IdxW-1:0] n;
    n       = '0;
    clips_d = '0;
    if (errc_q) begin
      clips_d[n] = ClipError;
      n          = n + 1'b1;
    end else if (zeroc_q) begin
      clips_d[0] = ClipZero;
      clips_d[1] = ClipCm;
      n          = 3'd2;
    end else begin
      if (thc_q != 2'd0) begin
        clips_d[n] = ClipW'(thc_q);
        n          = n + 1'b1;
        clips_d[n] = ClipThousand;
        n          = n + 1'b1;
      end
      if (huc_q != 4'd0) begin
        clips_d[n] = ClipW'(huc_q);
        n          = n + 1'b1;
        clips_d[n] = ClipHundred;
        n          = n + 1'b1;
      end
      if (tnc_q == 4'd1) begin
        clips_d[n] = ClipTeenBase + ClipW'(onc_q);
        n          = n + 1'b1;
      end else begin
        if (tnc_q != 4'd0) begin
          clips_d[n] = ClipTensBase + ClipW'(tnc_q);
          n          = n + 1'b1;
        end
        if (onc_q != 4'd0) begin
          clips_d[n] = ClipW'(onc_q);
          n          = n + 1'b1;
        end
      end
      clips_d[n] = ClipCm;
      n          = n + 1'b1;
    end
    cnt_d = n;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= in_i.valid;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      erra_q  <= in_i.err;
      zeroa_q <= (in_i.dist_cm == '0);
      tha_q   <= tha_d;
      rema_q  <= rema_d;
      errb_q  <= erra_q;
      zerob_q <= zeroa_q;
      thb_q   <= tha_q;
      hub_q   <= hub_d;
      remb_q  <= remb_d;
      errc_q  <= errb_q;
      zeroc_q <= zerob_q;
      thc_q   <= thb_q;
      huc_q   <= hub_q;
      tnc_q   <= tnc_d;
      onc_q   <= onc_d;
      clips_q <= clips_d;
      cnt_q   <= cnt_d;
    end
  end

  assign out_o.valid = vd_q;
  assign out_o.clips = clips_q;
  assign out_o.cnt   = cnt_q;

  // A speakable distance never reaches 4000.
  `ASSERT_AT(a_dist_speakable, clk_i, rst_ni,
             (in_i.valid && !in_i.err) |-> (in_i.dist_cm < SpeakLimit[LimW-1:0]))

endmodule

// ----- rtl/core/dtsc_emit.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dtsc_emit
  import dtsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  clip_list_t list_i,
  output logic       load_o,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,  // [4:0] clip, [7:5] zero
  output logic       m_axis_tlast   // last_clip
);

  logic                           busy_q;
  logic [MaxClips-1:0][ClipW-1:0] clips_q;
  logic [CntW-1:0]                cnt_q;
  logic [IdxW-1:0]                idx_q;
  logic                           last, take;

  // Handshake on the output and end of the current list.
  assign last   = (idx_q == cnt_q - 1'b1);
  assign take   = busy_q && m_axis_tready;
  assign load_o = !busy_q || (take && last);

  // Control: busy flag and clip index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (load_o) begin
      busy_q <= list_i.valid;
      idx_q  <= '0;
    end else if (take) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // The held clip list.
  always_ff @(posedge clk_i) begin
    if (load_o) begin
      clips_q <= list_i.clips;
      cnt_q   <= list_i.cnt;
    end
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tdata  = {3'b000, clips_q[idx_q]};
  assign m_axis_tlast  = last;

  `ASSERT_AT(a_idx_in_range, clk_i, rst_ni, busy_q |-> (idx_q < cnt_q))
  `ASSERT_NEVER_AT(a_cnt_nonzero, clk_i, rst_ni, busy_q && (cnt_q == '0))
  `ASSERT_AT(a_idx_advances, clk_i, rst_ni,
             (take && !last) |=> (busy_q && (idx_q == $past(idx_q) + 1'b1)))

endmodule
